/* rtl/bdeq_pkg.sv */
// Shared types and codes for the bounded double-ended queue.
// Used by bdeq_cell and bounded_double_ended_queue; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package bdeq_pkg;

    // Default number of storage cells
    localparam int DEPTH_DEFAULT = 16;

    // Width of the count field in a result
    localparam int COUNT_W = 5;

    // Operation codes carried in the kind field
    localparam logic [2:0] KIND_PUSH_FRONT = 3'd0;
    localparam logic [2:0] KIND_PUSH_BACK  = 3'd1;
    localparam logic [2:0] KIND_POP_FRONT  = 3'd2;
    localparam logic [2:0] KIND_POP_BACK   = 3'd3;
    localparam logic [2:0] KIND_QUERY      = 3'd4;

    // Input transaction payload
    typedef struct packed {
        logic [2:0]         kind;
        logic signed [31:0] value;
    } t_in;

    // Result transaction payload
    typedef struct packed {
        logic signed [31:0]   front_value;
        logic signed [31:0]   back_value;
        logic [COUNT_W-1:0]   count;
        logic                 is_empty;
        logic                 is_full;
        logic                 rejected;
    } t_out;

    // Qualified commands broadcast to every cell
    typedef struct packed {
        logic add_front;
        logic add_back;
        logic take_front;
        logic take_back;
    } t_cmd;

endpackage

`default_nettype wire

/* rtl/bounded_double_ended_queue.sv */
// Top level of the bounded double-ended queue: decode, count and result register.
// Depends on bdeq_pkg and bdeq_cell.
`timescale 1ns / 1ps
`default_nettype none

// The deque keeps its values in a row of DEPTH cells with the front always in
// cell 0; a push or pop at the front shifts every cell one place, while a push
// or pop at the back touches only the boundary cell. One transaction is taken
// every clock cycle unless the result output stalls, and its result appears in
// the following cycle, once the cell row has registered the new contents. A new
// transaction is taken while the result output is empty or being taken in the
// same cycle. A push while full is dropped and flagged as rejected; a pop while
// empty changes nothing. Values of an empty deque read as 0.
module bounded_double_ended_queue #(
    parameter int DEPTH = bdeq_pkg::DEPTH_DEFAULT
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  wire bdeq_pkg::t_in  i_in,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output bdeq_pkg::t_out      o_out
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic signed [31:0] w_data [DEPTH];
    logic [DEPTH-1:0]   w_valid;
    logic [DEPTH-1:0]   w_last;

    logic               w_accept;
    logic               w_full;
    logic               w_empty;
    logic               w_reject;
    bdeq_pkg::t_cmd     w_cmd;

    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic               r_out_valid;
    logic               r_rejected;
    logic signed [31:0] w_back;

    assign w_full     = w_valid[DEPTH-1];
    assign w_empty    = !w_valid[0];
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;

    // Decode the operation and qualify it against full and empty
    always_comb begin
        w_cmd    = '0;
        w_reject = 1'b0;
        unique case (i_in.kind)
            bdeq_pkg::KIND_PUSH_FRONT: begin
                w_cmd.add_front = w_accept && !w_full;
                w_reject        = w_full;
            end
            bdeq_pkg::KIND_PUSH_BACK: begin
                w_cmd.add_back = w_accept && !w_full;
                w_reject       = w_full;
            end
            bdeq_pkg::KIND_POP_FRONT: begin
                w_cmd.take_front = w_accept && !w_empty;
            end
            bdeq_pkg::KIND_POP_BACK: begin
                w_cmd.take_back = w_accept && !w_empty;
            end
            default: begin
                // query and unused codes change nothing
                w_cmd = '0;
            end
        endcase
    end

    // Build the cell chain
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [31:0] w_left_data;
        logic               w_left_valid;
        logic signed [31:0] w_right_data;
        logic               w_right_valid;

        if (g == 0) begin : g_head
            assign w_left_data  = i_in.value;
            assign w_left_valid = 1'b1;
        end else begin : g_mid_left
            assign w_left_data  = w_data[g-1];
            assign w_left_valid = w_valid[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign w_right_data  = '0;
            assign w_right_valid = 1'b0;
        end else begin : g_mid_right
            assign w_right_data  = w_data[g+1];
            assign w_right_valid = w_valid[g+1];
        end

        bdeq_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_cmd         (w_cmd),
            .i_value       (i_in.value),
            .i_left_data   (w_left_data),
            .i_left_valid  (w_left_valid),
            .i_right_data  (w_right_data),
            .i_right_valid (w_right_valid),
            .o_data        (w_data[g]),
            .o_valid       (w_valid[g]),
            .o_last        (w_last[g])
        );
    end

    // Advance the stored count
    always_comb begin
        n_count = r_count;
        if (w_cmd.add_front || w_cmd.add_back) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_cmd.take_front || w_cmd.take_back) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // Hold the result valid until it is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rejected <= w_reject;
        end
    end

    // Select the back value from the one cell flagged as last
    always_comb begin
        w_back = '0;
        for (int i = 0; i < DEPTH; i++) begin
            w_back = w_back | (w_data[i] & {32{w_last[i]}});
        end
    end

    // Drive the result from the registered cell state
    always_comb begin
        o_out             = '0;
        o_out.front_value = w_valid[0] ? w_data[0] : '0;
        o_out.back_value  = w_back;
        o_out.count       = bdeq_pkg::COUNT_W'(r_count);
        o_out.is_empty    = w_empty;
        o_out.is_full     = w_full;
        o_out.rejected    = r_rejected;
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

/* rtl/bdeq_cell.sv */
// One storage cell of the deque chain: a value and its occupied flag.
// Depends on bdeq_pkg for the command struct.
`timescale 1ns / 1ps
`default_nettype none

module bdeq_cell (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire bdeq_pkg::t_cmd i_cmd,
    input  wire signed [31:0]   i_value,
    input  wire signed [31:0]   i_left_data,
    input  wire                 i_left_valid,
    input  wire signed [31:0]   i_right_data,
    input  wire                 i_right_valid,
    output logic signed [31:0]  o_data,
    output logic                o_valid,
    output logic                o_last
);

    logic signed [31:0] r_data;
    logic signed [31:0] n_data;
    logic               r_valid;
    logic               n_valid;

    // Pick the next content from the neighbors or the pushed value
    always_comb begin
        n_data  = r_data;
        n_valid = r_valid;
        if (i_cmd.add_front) begin
            n_data  = i_left_data;
            n_valid = i_left_valid;
        end else if (i_cmd.take_front) begin
            n_data  = i_right_data;
            n_valid = i_right_valid;
        end else if (i_cmd.add_back) begin
            // first free cell takes the value
            if (!r_valid && i_left_valid) begin
                n_data  = i_value;
                n_valid = 1'b1;
            end
        end else if (i_cmd.take_back) begin
            // last occupied cell lets go
            if (r_valid && !i_right_valid) begin
                n_valid = 1'b0;
            end
        end
    end

    // Hold the payload
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    // Clear the occupied flag on reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_data  = r_data;
    assign o_valid = r_valid;
    assign o_last  = r_valid && !i_right_valid;

endmodule

`default_nettype wire
